>>> rtl/core/tandem_repeat_anchor_marker_macros.svh
// Assertion macros for the tandem repeat anchor marker.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TANDEM_REPEAT_ANCHOR_MARKER_MACROS_SVH
`define TANDEM_REPEAT_ANCHOR_MARKER_MACROS_SVH

// same-cycle implication
`define TRAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tram assertion failed");

// next-cycle implication
`define TRAM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tram assertion failed");

`endif

>>> rtl/core/tram_pkg.sv
// Package for the tandem repeat anchor marker: payload types, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package tram_pkg;

  localparam logic [2:0] CODE_N       = 3'd4;
  localparam logic [7:0] SPAN_MAX     = 8'd255;
  localparam int         MAX_UNIT_DEF = 8;
  localparam int         WINDOW_DEF   = 64;
  localparam int         WINDOW_MAX   = 64;
  localparam int         QUEUE_DEF    = 2;
  localparam int         LEN_W        = $clog2(WINDOW_MAX);
  localparam int         FILL_W       = $clog2(WINDOW_MAX + 1);
  localparam int         CFG_W        = 7;
  localparam logic [CFG_W-1:0] MIN_SPAN_RST = 7'd8;

  typedef struct packed {
    logic [2:0] base_code;
    logic       end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic is_anchor;
    logic last;
  } out_item_t;

  // classified base handed from front to back
  typedef struct packed {
    logic             eos;
    logic             mark;
    logic [LEN_W-1:0] clear_len;
  } rec_t;

  typedef struct packed {
    logic              flushing;
    logic [FILL_W-1:0] fill;
  } back_stat_t;

endpackage

>>> rtl/core/tram_front.sv
// Front part: base history and per-unit span counters, classifies each base.
// Depends on tram_pkg.
`timescale 1ns / 1ps

module tram_front import tram_pkg::*; #(
  parameter int MAX_UNIT = MAX_UNIT_DEF,
  parameter int WINDOW   = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  in_item_t         item,
  input  logic [CFG_W-1:0] min_span,
  output rec_t             rec
);

  logic [2:0]      hist_r   [MAX_UNIT];
  logic [7:0]      span_r   [MAX_UNIT];
  logic [7:0]      span_nxt [MAX_UNIT];
  logic [2:0]      base_c;
  logic [WINDOW:0] therm;
  logic            mark;
  logic [LEN_W-1:0] clr_len;

  assign base_c = (item.base_code > CODE_N) ? CODE_N : item.base_code;

  always_comb begin
    logic       match;
    logic       hit;
    logic       trig;
    logic [8:0] two_k;
    logic [7:0] len;
    mark  = 1'b0;
    therm = '0;
    for (int k = 0; k < MAX_UNIT; k++) begin
      match = (hist_r[k] != CODE_N) && (hist_r[k] == base_c);
      if (match) begin
        span_nxt[k] = (span_r[k] == SPAN_MAX) ? SPAN_MAX : span_r[k] + 8'd1;
      end else begin
        span_nxt[k] = 8'(k + 1);
      end
      two_k = 9'(2 * (k + 1));
      hit   = ({1'b0, span_nxt[k]} >= two_k) && (span_nxt[k] >= {1'b0, min_span});
      trig  = hit && (({1'b0, span_nxt[k]} == two_k) || (span_nxt[k] == {1'b0, min_span}));
      mark  = mark | hit;
      len   = span_nxt[k] - 8'd1;
      for (int i = 1; i < WINDOW; i++) begin
        therm[i] = therm[i] | (trig && (len >= 8'(i)));
      end
    end
  end

  // thermometer to length: the top set bit
  always_comb begin
    clr_len = '0;
    for (int i = 1; i < WINDOW; i++) begin
      clr_len = clr_len | ((therm[i] && !therm[i+1]) ? LEN_W'(i) : '0);
    end
  end

  assign rec.eos       = item.end_of_sequence;
  assign rec.mark      = mark | therm[0];
  assign rec.clear_len = clr_len;

  always_ff @(posedge clk) begin
    if (!rst_n || (take && item.end_of_sequence)) begin
      for (int k = 0; k < MAX_UNIT; k++) begin
        hist_r[k] <= CODE_N;
        span_r[k] <= 8'(k + 1);
      end
    end else if (take) begin
      hist_r[0] <= base_c;
      for (int k = 1; k < MAX_UNIT; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
      for (int k = 0; k < MAX_UNIT; k++) begin
        span_r[k] <= span_nxt[k];
      end
    end
  end

endmodule

>>> rtl/core/tram_queue.sv
// Short queue of classified bases between front and back.
// Depends on tram_pkg.
`timescale 1ns / 1ps

module tram_queue import tram_pkg::*; #(
  parameter int DEPTH = QUEUE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t wr_rec,
  output logic full,
  input  logic pop,
  output logic empty,
  output rec_t rd_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_rec = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tram_back.sv
// Back part: anchor flag window, range clears, emission and end flush.
// Depends on tram_pkg.
`timescale 1ns / 1ps

module tram_back import tram_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rec_t       rec,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output out_item_t  out_data,
  output back_stat_t stat
);

  localparam int IDXW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNTW = $clog2(WINDOW + 1);

  logic [WINDOW-1:0] win_r, win_nxt, shifted;
  logic [CNTW-1:0]   fill_r, fill_nxt, fill_inc;
  logic              flush_r, flush_nxt;
  logic [IDXW-1:0]   idx_r, idx_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         od_r, od_nxt;
  logic              can_out;

  assign can_out   = !ov_r || out_pop;
  assign q_pop     = !flush_r && !q_empty && can_out;
  assign out_empty = !ov_r;
  assign out_data  = od_r;
  assign stat.flushing = flush_r;
  assign stat.fill     = FILL_W'(fill_r);

  always_comb begin
    shifted    = {win_r[WINDOW-2:0], 1'b1};
    shifted[0] = !rec.mark;
    for (int i = 1; i < WINDOW; i++) begin
      if (LEN_W'(i) <= rec.clear_len) begin
        shifted[i] = 1'b0;
      end
    end
    fill_inc = (fill_r == CNTW'(WINDOW)) ? fill_r : fill_r + 1'b1;
  end

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_pop;
    od_nxt    = od_r;
    if (q_pop) begin
      win_nxt = shifted;
      if (rec.eos) begin
        flush_nxt = 1'b1;
        idx_nxt   = IDXW'(fill_inc - 1'b1);
        fill_nxt  = fill_inc;
      end else if (fill_inc == CNTW'(WINDOW)) begin
        ov_nxt           = 1'b1;
        od_nxt.is_anchor = shifted[WINDOW-1];
        od_nxt.last      = 1'b0;
        fill_nxt         = CNTW'(WINDOW - 1);
      end else begin
        fill_nxt = fill_inc;
      end
    end else if (flush_r && can_out) begin
      ov_nxt           = 1'b1;
      od_nxt.is_anchor = win_r[idx_r];
      od_nxt.last      = (idx_r == '0);
      if (idx_r == '0) begin
        flush_nxt = 1'b0;
        fill_nxt  = '0;
        win_nxt   = '1;
      end else begin
        idx_nxt  = idx_r - 1'b1;
        fill_nxt = fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '1;
      fill_r  <= '0;
      flush_r <= 1'b0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      flush_r <= flush_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

endmodule

>>> rtl/core/tandem_repeat_anchor_marker.sv
// Tandem repeat anchor marker, top level.
// Depends on tram_pkg, tram_front, tram_queue, tram_back and the macros header.
//
// Use: bases enter on the in_ queue port (in_push / in_full, in_data), one per
// transfer. Each result transfers on the out_ queue port (out_empty / out_pop,
// out_data) and flags one earlier position: is_anchor is 1 outside every
// detected tandem repeat. The min_repeat_span register is written on cfg_
// (cfg_valid / cfg_ready, cfg_ready always high). The user must write it only
// while the block is idle; the block itself does not enforce this. Throughput:
// one base per cycle while the queue is not full. The front classifies a base
// in the cycle it is taken; the back takes it from a QUEUE_DEPTH entry queue.
// Once WINDOW-1 bases are pending, each base the back takes pushes the oldest
// flag into the output register. End of sequence: the back emits every pending
// flag, one per cycle while the receiver keeps up, oldest first, last on the
// final one, while the front keeps taking bases until the queue is full.
// Reset: history all N, span counters at their unit length, no pending flags,
// min_repeat_span 8. A stalled receiver holds the output register, then the
// back, then the queue fills and in_full rises.
`timescale 1ns / 1ps
`include "tandem_repeat_anchor_marker_macros.svh"

module tandem_repeat_anchor_marker import tram_pkg::*; #(
  parameter int MAX_UNIT    = MAX_UNIT_DEF,
  parameter int WINDOW      = WINDOW_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_item_t         in_data,
  output logic             out_empty,
  input  logic             out_pop,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] min_span_r;
  logic             take;
  rec_t             f_rec, q_rec;
  logic             q_full, q_empty, q_pop;
  back_stat_t       bk_stat;

  assign cfg_ready = 1'b1;
  assign take      = in_push && !q_full;
  assign in_full   = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_span_r <= MIN_SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_span_r <= cfg_data;
    end
  end

  tram_front #(
    .MAX_UNIT (MAX_UNIT),
    .WINDOW   (WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_data),
    .min_span (min_span_r),
    .rec      (f_rec)
  );

  tram_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (take),
    .wr_rec (f_rec),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_rec (q_rec)
  );

  tram_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (q_rec),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .stat      (bk_stat)
  );

  `TRAM_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty)
  `TRAM_ASSERT_IMP(a_no_pop_in_flush, bk_stat.flushing, !q_pop)
  `TRAM_ASSERT_IMP(a_fill_bound, 1'b1, bk_stat.fill <= FILL_W'(WINDOW))
  `TRAM_ASSERT_NXT(a_eos_starts_flush, q_pop && q_rec.eos, bk_stat.flushing)

endmodule
